FILE: rtl/huu_pkg.sv
// ----------------------------------------------------------------------------
// Hopfield unit update package
// Sizes, command codes, controller/datapath bundles and field saturation.
// ----------------------------------------------------------------------------
package huu_pkg;

    localparam int UNITS    = 64;
    localparam int UNIT_W   = $clog2(UNITS);
    localparam int W_DEPTH  = UNITS * UNITS;
    localparam int W_ADDR_W = $clog2(W_DEPTH);
    localparam int WEIGHT_W = 16;
    localparam int ACC_W    = WEIGHT_W + UNIT_W + 1;
    localparam int FIELD_W  = 23;
    localparam int SAT_W    = (ACC_W > FIELD_W) ? ACC_W : FIELD_W;

    localparam logic [1:0] CMD_LOAD_W = 2'd0;
    localparam logic [1:0] CMD_LOAD_A = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic signed [SAT_W-1:0] FIELD_MAX = SAT_W'(4194303);
    localparam logic signed [SAT_W-1:0] FIELD_MIN = SAT_W'(-4194304);

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [FIELD_W-1:0] t_field;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic rd_issue;
        logic decide;
        logic out_load;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_update;
        logic idx_ok;
        logic last_col;
        logic out_free;
    } t_dp_stat;

    function automatic t_field sat_field(input t_acc s);
        logic signed [SAT_W-1:0] x;
        x = SAT_W'(s);
        if (x > FIELD_MAX) begin
            x = FIELD_MAX;
        end else if (x < FIELD_MIN) begin
            x = FIELD_MIN;
        end
        return t_field'(x[FIELD_W-1:0]);
    endfunction

endpackage

FILE: rtl/huu_if.sv
// ----------------------------------------------------------------------------
// Hopfield unit update channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface huu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [5:0]         unit_index;
    logic [5:0]         column_index;
    logic signed [15:0] weight_value;
    logic               activation_bit;

    modport source (output valid, cmd, unit_index, column_index, weight_value,
                    activation_bit, input ready);
    modport sink   (input valid, cmd, unit_index, column_index, weight_value,
                    activation_bit, output ready);
endinterface

interface huu_out_if;
    logic               valid;
    logic               ready;
    logic               activation;
    logic               flipped;
    logic signed [22:0] net_input;

    modport source (output valid, activation, flipped, net_input, input ready);
    modport sink   (input valid, activation, flipped, net_input, output ready);
endinterface

FILE: rtl/huu_ram.sv
// ----------------------------------------------------------------------------
// Hopfield unit update RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module huu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/huu_ctrl.sv
// ----------------------------------------------------------------------------
// Hopfield unit update controller
// Sequences load, row walk, decision and result hand-off for one item.
// ----------------------------------------------------------------------------
module huu_ctrl
    import huu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No beat is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (i_stat.is_update && i_stat.idx_ok) ? S_READ : S_DONE;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_stat.last_col) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/huu_dp.sv
// ----------------------------------------------------------------------------
// Hopfield unit update datapath
// Weight and activation stores, row accumulator, decision and output register.
// ----------------------------------------------------------------------------
module huu_dp
    import huu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_stat           o_stat,
    input  logic [1:0]         i_cmd_code,
    input  logic [5:0]         i_unit_index,
    input  logic [5:0]         i_column_index,
    input  logic signed [15:0] i_weight_value,
    input  logic               i_activation_bit,
    input  logic signed [15:0] i_threshold,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_activation,
    output logic               o_flipped,
    output t_field             o_net_input
);

    // Latched item.
    logic [1:0]         r_cmd;
    logic [5:0]         r_unit;
    logic [5:0]         r_col;
    logic signed [15:0] r_wval;
    logic               r_abit;

    // Row walk.
    logic [UNIT_W-1:0]  r_j;
    logic               r_rd_vld;
    logic [UNIT_W-1:0]  r_rd_col;
    t_acc               r_acc;
    logic               r_old;

    // Result and output registers.
    logic               r_res_act;
    logic               r_res_flip;
    t_field             r_res_field;
    logic               r_o_valid;
    logic               r_o_act;
    logic               r_o_flip;
    t_field             r_o_field;

    logic                  unit_ok;
    logic                  col_ok;
    logic                  w_we;
    logic [W_ADDR_W-1:0]   w_waddr;
    logic [W_ADDR_W-1:0]   w_raddr;
    logic [WEIGHT_W-1:0]   w_rdata;
    logic                  a_we;
    logic                  a_wdata;
    logic                  a_rdata;
    t_acc                  w_ext;
    logic signed [ACC_W:0] diff;
    logic                  now_act;

    assign unit_ok = (32'(r_unit) < UNITS);
    assign col_ok  = (32'(r_col) < UNITS);

    assign o_stat.is_update = (r_cmd == CMD_UPDATE);
    assign o_stat.idx_ok    = unit_ok && ((r_cmd != CMD_LOAD_W) || col_ok);
    assign o_stat.last_col  = (r_j == UNIT_W'(UNITS - 1));
    assign o_stat.out_free  = !r_o_valid || i_out_ready;

    assign w_we    = i_cmd.exec && (r_cmd == CMD_LOAD_W) && unit_ok && col_ok;
    assign w_waddr = W_ADDR_W'(32'(r_unit) * UNITS + 32'(r_col));
    assign w_raddr = W_ADDR_W'(32'(r_unit) * UNITS + 32'(r_j));

    huu_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_wval),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign a_we    = i_cmd.decide || (i_cmd.exec && (r_cmd == CMD_LOAD_A) && unit_ok);
    assign a_wdata = i_cmd.decide ? now_act : r_abit;

    huu_ram #(
        .WIDTH (1),
        .DEPTH (UNITS)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (UNIT_W'(r_unit)),
        .i_wdata (a_wdata),
        .i_raddr (r_j),
        .o_rdata (a_rdata)
    );

    assign w_ext   = ACC_W'($signed(w_rdata));
    assign diff    = (ACC_W + 1)'(r_acc) - (ACC_W + 1)'(i_threshold);
    // A field equal to the threshold fires.
    assign now_act = ~diff[ACC_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_cmd_code;
            r_unit <= i_unit_index;
            r_col  <= i_column_index;
            r_wval <= i_weight_value;
            r_abit <= i_activation_bit;
        end

        if (i_cmd.exec) begin
            r_j <= '0;
        end else if (i_cmd.rd_issue) begin
            r_j <= r_j + UNIT_W'(1);
        end
        r_rd_col <= r_j;

        if (i_cmd.exec) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc <= a_rdata ? (r_acc + w_ext) : (r_acc - w_ext);
        end

        // The unit's own activation passes by during the row walk.
        if (r_rd_vld && (32'(r_rd_col) == 32'(r_unit))) begin
            r_old <= a_rdata;
        end

        if (i_cmd.exec) begin
            r_res_flip  <= 1'b0;
            r_res_field <= '0;
            case (r_cmd)
                CMD_LOAD_A: r_res_act <= unit_ok ? r_abit : 1'b0;
                default:    r_res_act <= 1'b0;
            endcase
        end else if (i_cmd.decide) begin
            r_res_act   <= now_act;
            r_res_flip  <= now_act ^ r_old;
            r_res_field <= sat_field(r_acc);
        end

        if (i_cmd.out_load) begin
            r_o_act   <= r_res_act;
            r_o_flip  <= r_res_flip;
            r_o_field <= r_res_field;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_activation = r_o_act;
    assign o_flipped    = r_o_flip;
    assign o_net_input  = r_o_field;

endmodule

FILE: rtl/hopfield_unit_update_core.sv
// ----------------------------------------------------------------------------
// Hopfield unit update core
// Bipolar Hopfield engine: weight and activation loads and single-unit updates.
// ----------------------------------------------------------------------------
// Usage. Input beats arrive on i_in and each one produces exactly one result
// beat on o_out. A beat either loads one signed Q8.8 weight, loads one
// activation bit (1 is +1, 0 is -1), or updates one unit. An update walks the
// unit's weight row through the weight RAM, one column per cycle, adding or
// subtracting each weight by the sign of the matching activation, then
// compares the sum with the threshold and stores the new sign.
// Timing. The block handles one item at a time and takes no new beat until
// the last one's result is loaded into the output register. A load is
// accepted, executed and handed to the output register; an update also walks
// the row through the single read port of the weight RAM, drains the last
// read and decides before the hand-off.
// Stalls. The result sits in an output register; when the receiver holds
// o_out.ready low, the block finishes the next item and then waits with it
// until the register frees up, holding i_in.ready low meanwhile.
// Reset. i_rst_n is synchronous and active low; it idles the controller,
// empties the output register and sets the threshold to 0. The stores are
// not cleared, so every weight and activation must be loaded before use.
// Configuration. The APB port holds the threshold at address 0; write it
// only while no item is in flight.
// ----------------------------------------------------------------------------
module hopfield_unit_update_core
    import huu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    huu_in_if.sink      i_in,
    huu_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_ctrl_cmd          ctrl_cmd;
    t_dp_stat           dp_stat;
    logic signed [15:0] r_threshold;

    // The threshold register is the only entry of the register map; paddr[2]
    // selects the register index, so index 1 lands outside the map.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_threshold <= pwdata[15:0];
        end
    end

    // Reads return the threshold sign-extended, and zero elsewhere.
    assign prdata = paddr[2] ? 32'd0 : 32'($signed(r_threshold));

    // The controller decides when to accept a beat and steps the datapath.
    huu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    // The datapath owns both stores, the accumulator and the output register.
    huu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (ctrl_cmd),
        .o_stat           (dp_stat),
        .i_cmd_code       (i_in.cmd),
        .i_unit_index     (i_in.unit_index),
        .i_column_index   (i_in.column_index),
        .i_weight_value   (i_in.weight_value),
        .i_activation_bit (i_in.activation_bit),
        .i_threshold      (r_threshold),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_activation     (o_out.activation),
        .o_flipped        (o_out.flipped),
        .o_net_input      (o_out.net_input)
    );

`ifndef SYNTHESIS
    // One item at a time: after an accepted beat the input closes.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted a second beat while an item was in flight");

    // A flipped unit must agree with its reported field and the threshold.
    a_flip_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.flipped) |->
        (o_out.activation == (o_out.net_input >= 23'(r_threshold))))
        else $error("new activation disagrees with field and threshold");
`endif

endmodule
